FILE: rtl/vmm_pkg.sv
// Package with the word types, request codes, register map and helpers of the velocity monitor.
`default_nettype none
package vmm_pkg;

  localparam int WINDOW_LEN = 9;
  localparam int CNT_W      = $clog2(WINDOW_LEN + 1);
  localparam int WCNT_W     = 4;
  localparam int SPEED_W    = 16;
  localparam int LIMIT_W    = 15;
  localparam int THR_W      = 4;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  typedef enum logic [1:0] {
    REQ_MEAS = 2'd0,
    REQ_CMD  = 2'd1,
    REQ_INFO = 2'd2
  } req_code_t;

  typedef enum logic [1:0] {
    REG_TOLERANCE  = 2'd0,
    REG_ALARM_THR  = 2'd1,
    REG_DEADBAND_L = 2'd2,
    REG_DEADBAND_H = 2'd3
  } reg_index_t;

  localparam logic [LIMIT_W-1:0] TOLERANCE_RST  = 15'd100;
  localparam logic [THR_W-1:0]   ALARM_THR_RST  = 4'd7;
  localparam logic [LIMIT_W-1:0] DEADBAND_L_RST = 15'd1;
  localparam logic [LIMIT_W-1:0] DEADBAND_H_RST = 15'd1000;

  typedef struct packed {
    logic [1:0]                req_type;
    logic signed [SPEED_W-1:0] lin_value;
    logic signed [SPEED_W-1:0] ang_value;
    logic                      lost_flag;
  } in_word_t;

  typedef struct packed {
    logic              mismatch_warning;
    logic              alarm;
    logic [WCNT_W-1:0] warning_count;
  } out_word_t;

  // Absolute value of a speed; -32768 gives 32768, so one extra bit.
  function automatic logic [SPEED_W:0] speed_mag(input logic signed [SPEED_W-1:0] v);
    logic signed [SPEED_W:0] e;
    e = {v[SPEED_W-1], v};
    return v[SPEED_W-1] ? (SPEED_W+1)'(-e) : (SPEED_W+1)'(e);
  endfunction

  // True when |vel - cmd| <= tol, computed without overflow.
  function automatic logic within_tol(input logic signed [SPEED_W-1:0] vel,
                                      input logic signed [SPEED_W-1:0] cmd,
                                      input logic [LIMIT_W-1:0]        tol);
    logic signed [SPEED_W+1:0] d;
    logic signed [SPEED_W+1:0] t;
    d = {{2{vel[SPEED_W-1]}}, vel} - {{2{cmd[SPEED_W-1]}}, cmd};
    t = {3'b000, tol};
    return (d >= -t) && (d <= t);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/velocity_mismatch_monitor.sv
// Top level of the velocity mismatch monitor: input register, state update and result register.
`default_nettype none
// Velocity mismatch monitor. Each input word is a measured sample, a command or an info
// tick. A measured sample stores its linear speed and its negated angular speed (negating
// -32768 gives 32767), each only when its magnitude lies within the deadband limits. A
// command stores both commanded speeds. An info tick with lost_flag clear compares each
// measured speed against the current and then the previous command within the tolerance,
// shifts the warning bit into a window of the last nine warnings, raises the alarm and
// clears the window when the count reaches the threshold, and returns one result word;
// other words return nothing. Every word waits in the input register and is processed
// from there, so a result word shows at the outputs once its info tick leaves the input
// register; one word is taken every cycle while in_stall is low. The only back-pressure
// comes from the result register: while an unread result is held and out_stall is high,
// an info tick with lost_flag clear waiting in the input register holds, and in_stall
// goes high. The user must write registers through the APB-style port only while the
// block is idle; the block itself does not enforce this. The register map is tolerance
// at 0x0, alarm_threshold at 0x4, deadband_low at 0x8 and deadband_high at 0xC.
module velocity_mismatch_monitor (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  vmm_pkg::in_word_t              in_data,
  output logic                           out_valid,
  input  wire                            out_stall,
  output vmm_pkg::out_word_t             out_data,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [vmm_pkg::PADDR_W-1:0]    paddr,
  input  wire  [vmm_pkg::PDATA_W-1:0]    pwdata,
  output logic [vmm_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);
  import vmm_pkg::*;

  // Configuration registers.
  logic [LIMIT_W-1:0] tolerance_r;
  logic [THR_W-1:0]   alarm_thr_r;
  logic [LIMIT_W-1:0] deadband_l_r;
  logic [LIMIT_W-1:0] deadband_h_r;
  reg_index_t         reg_sel;
  logic               cfg_write;

  // Input register.
  logic     item_valid_r;
  in_word_t item_r;

  // Monitor state.
  logic signed [SPEED_W-1:0] meas_lin_r,  meas_lin_nxt;
  logic signed [SPEED_W-1:0] meas_ang_r,  meas_ang_nxt;
  logic signed [SPEED_W-1:0] cmd_lin_r,   cmd_lin_nxt;
  logic signed [SPEED_W-1:0] cmd_ang_r,   cmd_ang_nxt;
  logic signed [SPEED_W-1:0] prev_lin_r,  prev_lin_nxt;
  logic signed [SPEED_W-1:0] prev_ang_r,  prev_ang_nxt;
  logic [WINDOW_LEN-1:0]     window_r,    window_nxt;

  // Result register.
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_data_r,  out_data_nxt;

  logic                      is_meas, is_cmd, is_report;
  logic                      hold, fire;
  logic signed [SPEED_W-1:0] neg_ang;
  logic                      lin_ok, ang_ok;
  logic                      warn, alarm;
  logic [WINDOW_LEN:0]       shift_ext;
  logic [WINDOW_LEN-1:0]     shifted;
  logic [CNT_W-1:0]          count;

  // ---------------- configuration port ----------------
  assign pready    = 1'b1;
  assign reg_sel   = reg_index_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_sel)
      REG_TOLERANCE:  prdata = PDATA_W'(tolerance_r);
      REG_ALARM_THR:  prdata = PDATA_W'(alarm_thr_r);
      REG_DEADBAND_L: prdata = PDATA_W'(deadband_l_r);
      REG_DEADBAND_H: prdata = PDATA_W'(deadband_h_r);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tolerance_r  <= TOLERANCE_RST;
      alarm_thr_r  <= ALARM_THR_RST;
      deadband_l_r <= DEADBAND_L_RST;
      deadband_h_r <= DEADBAND_H_RST;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_TOLERANCE:  tolerance_r  <= pwdata[LIMIT_W-1:0];
        REG_ALARM_THR:  alarm_thr_r  <= pwdata[THR_W-1:0];
        REG_DEADBAND_L: deadband_l_r <= pwdata[LIMIT_W-1:0];
        REG_DEADBAND_H: deadband_h_r <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- input register and flow control ----------------
  assign is_meas   = item_r.req_type == REQ_MEAS;
  assign is_cmd    = item_r.req_type == REQ_CMD;
  assign is_report = (item_r.req_type == REQ_INFO) && !item_r.lost_flag;

  // Only a word that makes a result can be blocked by an unread result.
  assign hold     = is_report && out_valid_r && out_stall;
  assign fire     = item_valid_r && !hold;
  assign in_stall = item_valid_r && hold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (!in_stall) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r <= in_data;
    end
  end

  // ---------------- processing ----------------
  assign neg_ang = (item_r.ang_value == {1'b1, {(SPEED_W-1){1'b0}}}) ?
                   {1'b0, {(SPEED_W-1){1'b1}}} : -item_r.ang_value;

  assign lin_ok = (speed_mag(item_r.lin_value) >= {2'b00, deadband_l_r}) &&
                  (speed_mag(item_r.lin_value) <= {2'b00, deadband_h_r});
  assign ang_ok = (speed_mag(neg_ang) >= {2'b00, deadband_l_r}) &&
                  (speed_mag(neg_ang) <= {2'b00, deadband_h_r});

  // A speed mismatches when it is outside the tolerance of both commands.
  assign warn = (!within_tol(meas_lin_r, cmd_lin_r, tolerance_r) &&
                 !within_tol(meas_lin_r, prev_lin_r, tolerance_r)) ||
                (!within_tol(meas_ang_r, cmd_ang_r, tolerance_r) &&
                 !within_tol(meas_ang_r, prev_ang_r, tolerance_r));

  assign shift_ext = {window_r, warn};
  assign shifted   = shift_ext[WINDOW_LEN-1:0];

  always_comb begin
    count = '0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      count = count + CNT_W'(shifted[i]);
    end
  end

  assign alarm = (8'(count) >= 8'(alarm_thr_r));

  always_comb begin
    meas_lin_nxt  = meas_lin_r;
    meas_ang_nxt  = meas_ang_r;
    cmd_lin_nxt   = cmd_lin_r;
    cmd_ang_nxt   = cmd_ang_r;
    prev_lin_nxt  = prev_lin_r;
    prev_ang_nxt  = prev_ang_r;
    window_nxt    = window_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (fire) begin
      if (is_meas) begin
        if (lin_ok) begin
          meas_lin_nxt = item_r.lin_value;
        end
        if (ang_ok) begin
          meas_ang_nxt = neg_ang;
        end
      end else if (is_cmd) begin
        cmd_lin_nxt = item_r.lin_value;
        cmd_ang_nxt = item_r.ang_value;
      end else if (is_report) begin
        window_nxt   = alarm ? '0 : shifted;
        prev_lin_nxt = cmd_lin_r;
        prev_ang_nxt = cmd_ang_r;
        out_valid_nxt                 = 1'b1;
        out_data_nxt.mismatch_warning = warn;
        out_data_nxt.alarm            = alarm;
        out_data_nxt.warning_count    = WCNT_W'(count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meas_lin_r  <= '0;
      meas_ang_r  <= '0;
      cmd_lin_r   <= '0;
      cmd_ang_r   <= '0;
      prev_lin_r  <= '0;
      prev_ang_r  <= '0;
      window_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      meas_lin_r  <= meas_lin_nxt;
      meas_ang_r  <= meas_ang_nxt;
      cmd_lin_r   <= cmd_lin_nxt;
      cmd_ang_r   <= cmd_ang_nxt;
      prev_lin_r  <= prev_lin_nxt;
      prev_ang_r  <= prev_ang_nxt;
      window_r    <= window_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

FILE: rtl/vmm_checker.sv
// Port-level checker for the velocity mismatch monitor and its bind statement.
`default_nettype none
module vmm_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_stall,
  input vmm_pkg::in_word_t   in_data,
  input wire                 out_valid,
  input wire                 out_stall,
  input vmm_pkg::out_word_t  out_data
);
  import vmm_pkg::*;

  // A result the receiver has not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // A warning is shifted in before counting, so the count cannot be zero.
  a_warn_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.mismatch_warning |-> out_data.warning_count != '0)
    else $error("warning reported with an empty window");

  // The window never holds more warnings than its length.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.warning_count <= WCNT_W'(WINDOW_LEN))
    else $error("warning count beyond window length");

  // A new result follows an accepted info tick with tracking, through the input and result registers.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && !in_data.lost_flag &&
                               in_data.req_type == REQ_INFO, 2))
    else $error("result without a matching info word");

endmodule

bind velocity_mismatch_monitor vmm_checker u_vmm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

FILE: tb/velocity_mismatch_monitor_test.sv
// Self-checking testbench of the velocity mismatch monitor with its own prediction of every verdict.
`timescale 1ns / 1ps
module velocity_mismatch_monitor_test;
  import vmm_pkg::*;

  // The one request code that the package leaves out; the block must ignore it.
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  // Cycles after the last verdict before the block is surely empty of silent words.
  localparam int DRAIN_CYCLES = 4;
  // Hard ceiling on the run, far beyond the slowest correct run.
  localparam int CYCLE_LIMIT  = 400000;

  // Tracks the monitor's registers and speeds, and holds the verdicts still to come.
  class velocity_watch_model;
    logic [LIMIT_W-1:0]        tol;
    logic [THR_W-1:0]          thr;
    logic [LIMIT_W-1:0]        band_lo;
    logic [LIMIT_W-1:0]        band_hi;
    logic signed [SPEED_W-1:0] meas_lin;
    logic signed [SPEED_W-1:0] meas_ang;
    logic signed [SPEED_W-1:0] cmd_lin;
    logic signed [SPEED_W-1:0] cmd_ang;
    logic signed [SPEED_W-1:0] prev_lin;
    logic signed [SPEED_W-1:0] prev_ang;
    logic [WINDOW_LEN-1:0]     window;
    out_word_t                 pending_verdicts[$];
    int                        errors;

    function new();
      tol      = TOLERANCE_RST;
      thr      = ALARM_THR_RST;
      band_lo  = DEADBAND_L_RST;
      band_hi  = DEADBAND_H_RST;
      meas_lin = '0;
      meas_ang = '0;
      cmd_lin  = '0;
      cmd_ang  = '0;
      prev_lin = '0;
      prev_ang = '0;
      window   = '0;
      errors   = 0;
    endfunction

    function void set_reg(reg_index_t idx, logic [PDATA_W-1:0] v);
      case (idx)
        REG_TOLERANCE:  tol     = v[LIMIT_W-1:0];
        REG_ALARM_THR:  thr     = v[THR_W-1:0];
        REG_DEADBAND_L: band_lo = v[LIMIT_W-1:0];
        REG_DEADBAND_H: band_hi = v[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_verdicts.size();
    endfunction

    function bit in_band(logic signed [SPEED_W-1:0] s);
      int v;
      int lo;
      int hi;
      v  = s;
      lo = band_lo;
      hi = band_hi;
      if (v < 0) v = -v;
      return (v >= lo) && (v <= hi);
    endfunction

    function bit near(logic signed [SPEED_W-1:0] vel, logic signed [SPEED_W-1:0] cmd);
      int a;
      int c;
      int t;
      a = vel;
      c = cmd;
      t = tol;
      return (a >= c - t) && (a <= c + t);
    endfunction

    // Called for every word the block accepts.
    function void note_word(in_word_t w);
      logic signed [SPEED_W-1:0] neg_ang;
      out_word_t                 v;
      bit                        warn;
      int                        count;
      if (w.req_type == REQ_MEAS) begin
        // The raw angular speed is negated; the most negative value saturates.
        neg_ang = (w.ang_value == 16'sh8000) ? 16'sh7fff : -w.ang_value;
        if (in_band(w.lin_value)) meas_lin = w.lin_value;
        if (in_band(neg_ang)) meas_ang = neg_ang;
      end else if (w.req_type == REQ_CMD) begin
        cmd_lin = w.lin_value;
        cmd_ang = w.ang_value;
      end else if (w.req_type == REQ_INFO && !w.lost_flag) begin
        warn = (!near(meas_lin, cmd_lin) && !near(meas_lin, prev_lin)) ||
               (!near(meas_ang, cmd_ang) && !near(meas_ang, prev_ang));
        window = {window[WINDOW_LEN-2:0], warn};
        count = $countones(window);
        v.mismatch_warning = warn;
        v.alarm            = (count >= int'(thr));
        v.warning_count    = WCNT_W'(count);
        if (v.alarm) window = '0;
        prev_lin = cmd_lin;
        prev_ang = cmd_ang;
        pending_verdicts = {pending_verdicts, v};
      end
    endfunction

    task report_error(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // Called for every verdict word the block delivers.
    task check_verdict(out_word_t got);
      out_word_t want;
      if (pending_verdicts.size() == 0) begin
        report_error("verdict word with none expected");
      end else begin
        want = pending_verdicts[0];
        pending_verdicts.delete(0);
        if (got.mismatch_warning !== want.mismatch_warning)
          report_error($sformatf("mismatch_warning %b, expected %b",
                                 got.mismatch_warning, want.mismatch_warning));
        if (got.alarm !== want.alarm)
          report_error($sformatf("alarm %b, expected %b", got.alarm, want.alarm));
        if (got.warning_count !== want.warning_count)
          report_error($sformatf("warning_count %0d, expected %0d",
                                 got.warning_count, want.warning_count));
      end
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_word_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_word_t            out_data;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  velocity_watch_model  watch;
  int                   gap_pct;     // chance in a hundred that the sender idles a cycle
  int                   stall_pct;   // chance in a hundred that the receiver stalls a cycle
  int                   hold_left;   // cycles left of a long receiver hold-off
  int                   cycle_count;

  velocity_mismatch_monitor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  // The receiver decides its stall at each falling edge. A hold-off, once armed, keeps
  // the stall high for a counted stretch so that the block fills up and stalls its input.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Every verdict word is checked at the rising edge that moves it.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) watch.check_verdict(out_data);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // Offers one word, starting at a falling edge, and returns at the falling edge after
  // it was taken. The valid is only ever assigned once per edge, so a word that follows
  // directly keeps the valid high without a glitch.
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    // The stall seen right after the edge is the value that the edge sampled.
    do @(posedge clk); while (in_stall);
    watch.note_word(w);
    @(negedge clk);
  endtask

  task automatic send_fields(logic [1:0] req, logic signed [SPEED_W-1:0] lin,
                             logic signed [SPEED_W-1:0] ang, logic lost);
    in_word_t w;
    w.req_type  = req;
    w.lin_value = lin;
    w.ang_value = ang;
    w.lost_flag = lost;
    send_word(w);
  endtask

  // Stops offering and waits until every verdict has come, then lets a word that
  // causes no verdict leave the pipeline as well.
  task automatic settle();
    in_valid <= 1'b0;
    while (watch.pending() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // One register write: setup cycle, then access cycle until pready is seen.
  task automatic write_reg(reg_index_t idx, logic [PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    watch.set_reg(idx, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(logic [PDATA_W-1:0] tol, logic [PDATA_W-1:0] thr,
                           logic [PDATA_W-1:0] lo, logic [PDATA_W-1:0] hi);
    write_reg(REG_TOLERANCE, tol);
    write_reg(REG_ALARM_THR, thr);
    write_reg(REG_DEADBAND_L, lo);
    write_reg(REG_DEADBAND_H, hi);
  endtask

  // Mostly speeds around the deadband and near one another, so that tolerance and
  // deadband decisions go both ways; the rest are extremes and raw 16-bit patterns.
  function automatic logic signed [SPEED_W-1:0] pick_speed();
    int r;
    r = $urandom_range(99);
    if (r < 10) begin
      case ($urandom_range(5))
        0: return 16'sh8000;
        1: return 16'sh7fff;
        2: return 16'sh8001;
        3: return 16'sh0001;
        4: return 16'shffff;
        default: return 16'sh0000;
      endcase
    end else if (r < 30) begin
      return SPEED_W'($urandom);
    end
    return SPEED_W'($urandom_range(2400) - 1200);
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int       r;
    r = $urandom_range(99);
    if (r < 35)      w.req_type = REQ_MEAS;
    else if (r < 60) w.req_type = REQ_CMD;
    else if (r < 95) w.req_type = REQ_INFO;
    else             w.req_type = REQ_UNUSED;
    w.lin_value = pick_speed();
    w.ang_value = pick_speed();
    // Tracking is lost now and then on an info word; on other words the flag is noise.
    if (w.req_type == REQ_INFO) w.lost_flag = ($urandom_range(9) == 0);
    else                        w.lost_flag = 1'($urandom_range(1));
    return w;
  endfunction

  // Sends the given number of random words.
  task automatic random_phase(int count);
    in_word_t w;
    int       done;
    done = 0;
    while (done < count) begin
      w = random_word();
      send_word(w);
      done++;
    end
  endtask

  initial begin
    in_word_t w;
    clk       = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    gap_pct   = 0;
    stall_pct = 0;
    hold_left = 0;
    watch     = new();

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words under the reset settings: tolerance 100, threshold 7,
    // deadband from 1 to 1000.
    send_fields(REQ_INFO, 16'sd0, 16'sd0, 1'b0);
    send_fields(REQ_MEAS, 16'sd500, -16'sd500, 1'b0);
    send_fields(REQ_CMD, 16'sd500, 16'sd500, 1'b0);
    send_fields(REQ_INFO, 16'sd0, 16'sd0, 1'b0);
    // Both magnitudes far above the deadband, so nothing is stored.
    send_fields(REQ_MEAS, 16'sh8000, 16'sh8000, 1'b0);
    // Exactly on the upper deadband edge, so both are stored.
    send_fields(REQ_MEAS, 16'sd1000, -16'sd1000, 1'b0);
    // Zero lies below the lower deadband edge.
    send_fields(REQ_MEAS, 16'sd0, 16'sd0, 1'b0);
    send_fields(REQ_CMD, 16'sh7fff, 16'sh8000, 1'b0);
    // Lost tracking and the unused request code both give no verdict.
    send_fields(REQ_INFO, 16'sd0, 16'sd0, 1'b1);
    send_fields(REQ_INFO, 16'sd0, 16'sd0, 1'b0);
    send_fields(REQ_UNUSED, 16'sh7fff, 16'sh8000, 1'b1);
    send_fields(REQ_INFO, 16'shffff, 16'shffff, 1'b0);
    settle();

    // Widest tolerance, threshold zero so every compared tick raises the alarm, and
    // crossed deadband bounds so no measured value is accepted.
    configure(32'd32767, 32'd0, 32'd32767, 32'd0);
    send_fields(REQ_MEAS, 16'sh8000, 16'sh8000, 1'b0);
    send_fields(REQ_INFO, 16'sd0, 16'sd0, 1'b0);
    send_fields(REQ_INFO, 16'sd0, 16'sd0, 1'b0);
    settle();

    // Zero tolerance, a threshold above the window so the alarm never fires, and the
    // full deadband. Negating the most negative angular value saturates; the linear
    // one still falls outside, since its magnitude is one past the top.
    configure(32'd0, 32'd15, 32'd0, 32'd32767);
    send_fields(REQ_MEAS, 16'sh8000, 16'sh8000, 1'b0);
    send_fields(REQ_MEAS, 16'sh7fff, 16'sh7fff, 1'b0);
    send_fields(REQ_CMD, 16'sd0, 16'sd0, 1'b0);
    // Every tick warns, so the window fills up to its full count of nine.
    repeat (10) send_fields(REQ_INFO, 16'sd0, 16'sd0, 1'b0);
    settle();

    // Random part, first with no idling on either side.
    configure(32'd100, 32'd7, 32'd1, 32'd1000);
    random_phase(340);
    settle();

    // Long receiver hold-off while the sender keeps offering info ticks: the result
    // register and input register fill up, and the block must stall its input.
    @(posedge clk);
    hold_left = 300;
    @(negedge clk);
    repeat (40) begin
      w = random_word();
      w.req_type  = REQ_INFO;
      w.lost_flag = 1'b0;
      send_word(w);
    end
    // The sender then pauses until every verdict has come.
    settle();

    // Sender idle most of the time, alarm on the first warning.
    gap_pct   = 64;
    stall_pct = 0;
    configure(32'd0, 32'd1, 32'd0, 32'd32767);
    random_phase(330);
    settle();

    // Receiver stalling most of the time, threshold equal to the window length.
    gap_pct   = 0;
    stall_pct = 64;
    configure(32'd300, 32'd9, 32'd50, 32'd800);
    random_phase(330);
    settle();

    // Both sides idle now and then, random settings with noise in the upper data bits.
    gap_pct   = 28;
    stall_pct = 28;
    configure({16'($urandom_range(65535)), 1'b0, 15'($urandom_range(600))},
              {28'($urandom), 4'($urandom_range(15))},
              {17'($urandom), 15'($urandom_range(400))},
              {17'($urandom), 15'($urandom_range(300, 32767))});
    random_phase(330);
    settle();

    repeat (10) @(negedge clk);
    if (watch.errors == 0 && watch.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/vmm_pkg.sv
rtl/velocity_mismatch_monitor.sv
rtl/vmm_checker.sv
tb/velocity_mismatch_monitor_test.sv
